/* hw/rtl/phase_accumulator_oscillator_macros.svh */
// Assertion macros shared by the oscillator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PHASE_ACCUMULATOR_OSCILLATOR_MACROS_SVH
`define PHASE_ACCUMULATOR_OSCILLATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PAO_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PAO_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pao_pkg.sv */
// Package for the phase accumulator oscillator: sizes, register and
// waveform codes, the stage item struct and the quarter-wave sine table.
// Depends on nothing.
package pao_pkg;

  localparam int SINE_TABLE_BITS = 12;
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_W         = 32;
  localparam int AMP_W           = 15;
  localparam int WAVE_W          = 2;
  localparam int OUT_W           = 16;
  localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);
  localparam int ROM_AW          = SINE_TABLE_BITS - 1;
  localparam int ROM_DEPTH       = QUARTER + 1;
  localparam int MAG_W           = SAMPLE_BITS - 1;
  localparam int PROD_W          = SAMPLE_BITS + AMP_W + 1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd42852281;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RESET  = 15'd16384;

  // register indexes
  localparam logic [1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] REG_WAVEFORM   = 2'd2;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE    = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE  = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW     = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_SILENCE = 2'd3;

  // item moving from the phase stage to the scaling stage
  typedef struct packed {
    logic [WAVE_W-1:0]      wave;
    logic                   sine_neg;
    logic                   square_pos;
    logic [SAMPLE_BITS-1:0] saw;
    logic [AMP_W-1:0]       amp;
  } pao_item_t;

  typedef logic [MAG_W-1:0] sine_q_t [ROM_DEPTH];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'd1073741824;
  localparam longint          FULL_SCALE  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint unsigned TAYLOR_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // First quadrant magnitudes, evaluated at elaboration from a Q30 series.
  function automatic sine_q_t sine_quarter_table();
    sine_q_t         tq;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          mag;
    for (int m = 0; m <= QUARTER; m++) begin
      x = (HALF_PI_Q30 * longint'(m) + longint'(QUARTER >> 1)) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 12; i++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      mag = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      tq[m] = mag[MAG_W-1:0];
    end
    return tq;
  endfunction

endpackage

/* hw/rtl/pao_sine_rom.sv */
// Quarter-wave sine magnitude ROM with registered read data.
// Depends on pao_pkg for the table contents and sizes.
module pao_sine_rom
  import pao_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROM_AW-1:0] addr,
  output logic [MAG_W-1:0]  mag
);

  localparam sine_q_t SINE_Q = sine_quarter_table();

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= SINE_Q[addr];
    end
  end

endmodule

/* hw/rtl/pao_scale.sv */
// Waveform select, amplitude multiply and saturating output register.
// Depends on pao_pkg; fed by the phase stage of the top level.
module pao_scale
  import pao_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pao_item_t        item,
  input  logic [MAG_W-1:0] sine_mag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] sample
);

  localparam logic signed [PROD_W-1:0] SAT_MAX = 32767;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -32768;

  logic                          prod_valid;
  logic signed [PROD_W-1:0]      prod;
  logic                          prod_ready;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] value;
  logic signed [SAMPLE_BITS-1:0] sine_val;
  logic signed [PROD_W-1:0]      shifted;
  logic [OUT_W-1:0]              sample_next;

  assign out_free   = !out_valid || out_ready;
  assign prod_ready = !prod_valid || out_free;
  assign in_ready   = prod_ready;

  assign sine_val = item.sine_neg ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  always_comb begin
    case (item.wave)
      WAVE_SINE:    value = sine_val;
      WAVE_SQUARE:  value = item.square_pos ? $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}})
                                            : $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
      WAVE_SAW:     value = $signed(item.saw);
      WAVE_SILENCE: value = '0;
      default:      value = '0;
    endcase
  end

  // floor shift by 15, then clamp to the output range
  assign shifted = prod >>> 15;

  always_comb begin
    if (shifted > SAT_MAX) begin
      sample_next = 16'h7fff;
    end else if (shifted < SAT_MIN) begin
      sample_next = 16'h8000;
    end else begin
      sample_next = shifted[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= in_valid;
    end
  end

  // widen both operands first so the full product is kept
  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod <= PROD_W'(value) * PROD_W'($signed({1'b0, item.amp}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && prod_valid) begin
      sample <= sample_next;
    end
  end

endmodule

/* hw/rtl/phase_accumulator_oscillator.sv */
// Phase accumulator oscillator top level: configuration registers, phase
// accumulator and ROM address stage. Depends on pao_pkg, pao_sine_rom, pao_scale.
//
//   channel | dir | payload                         | moves on
//   s_*     | in  | tdata[0] tick, [7:1] zero       | s_tvalid && s_tready
//   m_*     | out | tdata[15:0] sample (signed)     | m_tvalid && m_tready
//   wr_*    | in  | wr_index register, wr_data value| wr_en
//
// One request per cycle sustained while the output is not stalled; a sample
// passes the ROM read, product and output registers in that order. Each stage
// takes a new item whenever it is empty or its successor moves, so bubbles
// close up while the output waits. A tick of zero is taken but yields nothing.
// Synchronous reset clears phase and valid bits, presets the config registers.
`include "phase_accumulator_oscillator_macros.svh"

module phase_accumulator_oscillator
  import pao_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [0] tick, [7:1] zero
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,   // [15:0] sample
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [PHASE_W-1:0]  wr_data
);

  logic [PHASE_W-1:0]     phase_step;
  logic [AMP_W-1:0]       amplitude;
  logic [WAVE_W-1:0]      waveform;
  logic [PHASE_W-1:0]     phase;
  logic                   accept;
  logic                   tick;
  logic                   adv;
  logic                   stage_valid;
  logic                   scale_ready;
  pao_item_t              stage_item;
  pao_item_t              item_next;
  logic [SINE_TABLE_BITS-1:0] rom_k;
  logic [1:0]             quad;
  logic [ROM_AW-1:0]      rom_r;
  logic [ROM_AW-1:0]      rom_addr;
  logic [MAG_W-1:0]       sine_mag;

  localparam logic [ROM_AW-1:0] QUARTER_A = ROM_AW'(QUARTER);

  assign adv      = !stage_valid || scale_ready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign tick     = s_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
      amplitude  <= AMPLITUDE_RESET;
      waveform   <= WAVE_SINE;
    end else if (wr_en) begin
      case (wr_index)
        REG_PHASE_STEP: phase_step <= wr_data;
        REG_AMPLITUDE:  amplitude  <= wr_data[AMP_W-1:0];
        REG_WAVEFORM:   waveform   <= wr_data[WAVE_W-1:0];
        default:        ;
      endcase
    end
  end

  // advance only on a real tick; the sample uses the phase before the add
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept && tick) begin
      phase <= phase + phase_step;
    end
  end

  // fold the full-wave index into the first quadrant
  assign rom_k    = phase[PHASE_W-1 -: SINE_TABLE_BITS];
  assign quad     = rom_k[SINE_TABLE_BITS-1 -: 2];
  assign rom_r    = {1'b0, rom_k[SINE_TABLE_BITS-3:0]};
  assign rom_addr = quad[0] ? QUARTER_A - rom_r : rom_r;

  always_comb begin
    item_next.wave       = waveform;
    item_next.sine_neg   = quad[1];
    item_next.square_pos = (phase != '0) && !phase[PHASE_W-1];
    item_next.saw        = {~phase[PHASE_W-1], phase[PHASE_W-2 -: SAMPLE_BITS-1]};
    item_next.amp        = amplitude;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (adv) begin
      stage_valid <= accept && tick;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_item <= item_next;
    end
  end

  pao_sine_rom u_rom (
    .clk  (clk),
    .en   (adv),
    .addr (rom_addr),
    .mag  (sine_mag)
  );

  pao_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid),
    .in_ready  (scale_ready),
    .item      (stage_item),
    .sine_mag  (sine_mag),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sample    (m_tdata)
  );

  `PAO_ASSERT_NEXT(a_phase_adv, clk, rst, accept && tick, phase == $past(phase) + $past(phase_step), "phase did not advance by the step on a tick")
  `PAO_ASSERT_NEXT(a_phase_hold, clk, rst, !(accept && tick), phase == $past(phase), "phase moved without a tick")
  `PAO_ASSERT_NOW(a_no_drop, clk, rst, stage_valid && !scale_ready, !s_tready, "phase stage took a request while full and stalled")
  `PAO_ASSERT_NEXT(a_stage_load, clk, rst, accept && !tick, !stage_valid, "empty tick produced a stage item")

endmodule

/* tb/sv/tb_phase_accumulator_oscillator.sv */
// Self-checking testbench for phase_accumulator_oscillator: directed table, then random
// phases of tick requests with register writes between them, checked against a local model.
// Depends on pao_pkg and the phase_accumulator_oscillator RTL.
`timescale 1ns / 1ps

module tb_phase_accumulator_oscillator;
  import pao_pkg::*;

  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          RANDOM_TICKS  = 1750;
  localparam int          CALM_TICKS    = 1500;
  localparam logic [1:0]  REG_NONE      = 2'd3;
  localparam int          ROWS          = 36;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [1:0]              reg_idx;
    logic [PHASE_W-1:0]      data;
    logic                    tick;
    logic                    pinned;
    logic signed [OUT_W-1:0] want;
  } stim_row_t;

  // Fixed values are typed in where they follow directly from the phase sequence.
  localparam stim_row_t DIRECTED [ROWS] = '{
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_WAVEFORM,   {30'h3FFF_FFFF, WAVE_SQUARE}, 1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_AMPLITUDE,  32'hFFFF_FFFF,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd32766},
    '{ROW_WRITE, REG_PHASE_STEP, 32'h8000_0000,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd32766},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, -16'sd32767},
    '{ROW_WRITE, REG_PHASE_STEP, 32'd4166410453,           1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd32766},
    '{ROW_WRITE, REG_PHASE_STEP, 32'h8000_0000,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, -16'sd32767},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, -16'sd32767},
    '{ROW_WRITE, REG_NONE,       32'hFFFF_FFFF,            1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_WAVEFORM,   {30'h1, WAVE_SAW},        1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, -16'sd32767},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP, 32'hFFFF_FFFF,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, -16'sd32767},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd32766},
    '{ROW_WRITE, REG_AMPLITUDE,  32'h0000_8000,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_AMPLITUDE,  32'd12345,                1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_WAVEFORM,   {30'h0, WAVE_SINE},       1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_PHASE_STEP, 32'h4000_0000,            1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_WAVEFORM,   {30'h0, WAVE_SILENCE},    1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_WAVEFORM,   {30'h0, WAVE_SAW},        1'b0, 1'b0, 16'sd0},
    '{ROW_TICK,  REG_PHASE_STEP, 32'd0,                    1'b1, 1'b0, 16'sd0}
  };

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;   // [0] tick, [7:1] zero
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;   // [15:0] sample
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [PHASE_W-1:0] wr_data;

  // local copy of the oscillator state and registers
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] step_cfg;
  logic [AMP_W-1:0]   amp_cfg;
  logic [WAVE_W-1:0]  wave_cfg;

  logic signed [OUT_W-1:0] pending_samples [$];
  int                      mismatches;

  // pinned value travels with the request it belongs to
  logic                    pin_valid;
  logic signed [OUT_W-1:0] pin_value;

  int gap_pct;
  int stall_pct;
  int stall_left;
  bit calm;

  phase_accumulator_oscillator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Full-wave sine entry k, built from the quarter-wave Q30 series by symmetry.
  function automatic longint sine_value(input logic [SINE_TABLE_BITS-1:0] k);
    int unsigned     quad;
    int unsigned     r;
    int unsigned     m;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          mag;
    quad = k >> (SINE_TABLE_BITS - 2);
    r = k & (QUARTER - 1);
    m = ((quad & 1) != 0) ? QUARTER - r : r;
    x = (HALF_PI_Q30 * m + (QUARTER >> 1)) >> (SINE_TABLE_BITS - 2);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int i = 1; i <= 12; i++) begin
      term = ((term * x2) >> 30) / 64'(2 * i * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    mag = (acc * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
    if (mag > FULL_SCALE) mag = FULL_SCALE;
    return (quad >= 2) ? -mag : mag;
  endfunction

  function automatic logic signed [OUT_W-1:0] oscillator_sample();
    longint v;
    longint s;
    case (wave_cfg)
      WAVE_SINE:   v = sine_value(phase_acc[PHASE_W-1 -: SINE_TABLE_BITS]);
      WAVE_SQUARE: v = (phase_acc != '0 && phase_acc < 32'h8000_0000) ?
                       FULL_SCALE : -FULL_SCALE - 1;
      WAVE_SAW:    v = longint'(phase_acc >> (PHASE_W - SAMPLE_BITS)) -
                       (64'sd1 <<< (SAMPLE_BITS - 1));
      default:     v = 0;
    endcase
    s = (v * longint'(amp_cfg)) >>> 15;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[OUT_W-1:0];
  endfunction

  // Track writes and requests, and check every sample that leaves.
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] want;
    if (rst) begin
      phase_acc = '0;
      step_cfg  = PHASE_STEP_RESET;
      amp_cfg   = AMPLITUDE_RESET;
      wave_cfg  = WAVE_SINE;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_PHASE_STEP: step_cfg = wr_data;
          REG_AMPLITUDE:  amp_cfg  = wr_data[AMP_W-1:0];
          REG_WAVEFORM:   wave_cfg = wr_data[WAVE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready && s_tdata[0]) begin
        want = pin_valid ? pin_value : oscillator_sample();
        pending_samples.push_back(want);
        phase_acc = phase_acc + step_cfg;
      end
      if (m_tvalid && m_tready) begin
        if (pending_samples.size() == 0) begin
          $error("sample with no request pending: actual %0d", $signed(m_tdata));
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (m_tdata !== want) begin
            $error("sample mismatch: expected %0d, actual %0d", want, $signed(m_tdata));
            mismatches++;
          end
        end
      end
    end
  end

  // Output side: hold off in random bursts.
  initial begin
    m_tready   = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_tick(input logic tick, input logic pinned,
                           input logic signed [OUT_W-1:0] want);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid  = 1'b1;
    s_tdata   = {7'd0, tick};
    pin_valid = pinned;
    pin_value = want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending, wait out every pending sample, then let the pipeline empty.
  task automatic drain_samples();
    @(negedge clk);
    s_tvalid  = 1'b0;
    pin_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PHASE_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  initial begin
    logic [WAVE_W-1:0]  wave_codes [4];
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0]   amp;
    bit                 busy;
    int                 ticks_sent;
    int                 run_len;
    wave_codes = '{WAVE_SINE, WAVE_SQUARE, WAVE_SAW, WAVE_SILENCE};
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    wr_en      = 1'b0;
    wr_index   = REG_PHASE_STEP;
    wr_data    = '0;
    pin_valid  = 1'b0;
    pin_value  = '0;
    mismatches = 0;
    gap_pct    = 0;
    stall_pct  = 0;
    calm       = 1'b0;
    busy       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        if (busy) drain_samples();
        busy = 1'b0;
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
      end else begin
        send_tick(DIRECTED[i].tick, DIRECTED[i].pinned, DIRECTED[i].want);
        busy = 1'b1;
      end
    end

    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      drain_samples();
      calm = (ticks_sent >= CALM_TICKS);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 25;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        2:       stall_pct = 25;
        default: stall_pct = 50;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       step = '0;
          1:       step = 32'hFFFF_FFFF;
          2:       step = 32'h8000_0000;
          3:       step = $urandom_range(1, 255);
          4:       step = $urandom_range(1, 1 << 24);
          default: step = $urandom;
        endcase
        write_reg(REG_PHASE_STEP, step);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 4))
          0:       amp = '0;
          1:       amp = 15'h7FFF;
          default: amp = $urandom_range(0, 32767);
        endcase
        write_reg(REG_AMPLITUDE, ($urandom & 32'hFFFF_8000) | amp);
      end
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_WAVEFORM,
                  ($urandom & 32'hFFFF_FFFC) | wave_codes[$urandom_range(0, 3)]);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_NONE, $urandom);
      end
      run_len = $urandom_range(60, 190);
      repeat (run_len) begin
        logic tick;
        tick = ($urandom_range(0, 9) != 0);
        send_tick(tick, 1'b0, '0);
        ticks_sent++;
      end
    end

    drain_samples();
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pao_pkg.sv
hw/rtl/pao_sine_rom.sv
hw/rtl/pao_scale.sv
hw/rtl/phase_accumulator_oscillator.sv
tb/sv/tb_phase_accumulator_oscillator.sv
